// ----- src/mvs_pkg.sv -----
// mvs_pkg: request codes, status codes, state encoding and item types
// of the version store. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mvs_pkg;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_FIND   = 2'd1,
    REQ_SWEEP  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_ORDER     = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPEND,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] stamp;
    logic [31:0] payload_handle;
    logic [15:0] payload_len;
  } req_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] found_stamp;
    logic [31:0] found_handle;
    logic [15:0] found_len;
    logic [4:0]  held_count;
  } rsp_item_t;

  typedef struct packed {
    logic [63:0] stamp;
    logic [31:0] handle;
    logic [15:0] len;
  } entry_t;

endpackage

`default_nettype wire

// ----- src/mvs_if.sv -----
// mvs_req_if, mvs_rsp_if: valid/ready channels for requests and results
// depends on mvs_pkg
`timescale 1ns / 1ps
`default_nettype none

interface mvs_req_if import mvs_pkg::*;;
  logic      valid;
  logic      ready;
  req_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mvs_rsp_if import mvs_pkg::*;;
  logic      valid;
  logic      ready;
  rsp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/mvcc_version_store.sv -----
// mvcc_version_store: top level, version ring memory plus sequencer
// depends on mvs_pkg, mvs_if, mvs_ram, mvs_ctrl
`timescale 1ns / 1ps
`default_nettype none

// Holds up to MAX_VERSIONS versions of one tuple as a ring in a single
// memory with one write and one registered read port. One request is
// worked at a time. An append reads the newest version, then compares
// and writes, then gives its result; a refused full append and the
// unused request code go straight to the result. A find or sweep
// examines the held versions newest first, one memory read per cycle,
// until a version matches or none is left. A stalled receiver holds the
// sequencer in its result step while the result register is still full.
// The result sits in an output register, so the next request is taken
// while a result still waits. The memory needs no clearing after reset.
module mvcc_version_store import mvs_pkg::*; #(
  parameter int MAX_VERSIONS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  mvs_req_if.sink   req,
  mvs_rsp_if.source rsp
);

  localparam int SW = $clog2(MAX_VERSIONS);

  logic          we;
  logic [SW-1:0] waddr;
  logic [SW-1:0] raddr;
  entry_t        wdata;
  entry_t        rdata;

  mvs_ctrl #(
    .MAX_VERSIONS(MAX_VERSIONS)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rsp   (rsp),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  mvs_ram #(
    .DEPTH(MAX_VERSIONS),
    .WIDTH($bits(entry_t))
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

// ----- src/mvs_ram.sv -----
// mvs_ram: simple dual-port memory, one write and one registered read
// per cycle. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mvs_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 112
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/mvs_ctrl.sv -----
// mvs_ctrl: request sequencer, ring pointers, newest-first scan and
// result register. depends on mvs_pkg, mvs_if; drives mvs_ram.
`timescale 1ns / 1ps
`default_nettype none

module mvs_ctrl import mvs_pkg::*; #(
  parameter int MAX_VERSIONS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  mvs_req_if.sink                              req,
  mvs_rsp_if.source                            rsp,
  output logic                                 we,
  output logic [$clog2(MAX_VERSIONS)-1:0]      waddr,
  output entry_t                               wdata,
  output logic [$clog2(MAX_VERSIONS)-1:0]      raddr,
  input  entry_t                               rdata
);

  localparam int SW = $clog2(MAX_VERSIONS);
  localparam int CW = $clog2(MAX_VERSIONS + 1);

  state_t          state, state_next;
  logic [SW-1:0]   oldest, oldest_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   nxt_pos, nxt_pos_next;
  logic [CW-1:0]   chk_pos, chk_pos_next;
  logic            chk_valid, chk_valid_next;
  logic [1:0]      req_q;
  logic [63:0]     stamp_q;
  logic [31:0]     handle_q;
  logic [15:0]     len_q;
  rsp_item_t       res, res_next;
  rsp_item_t       emit_item;
  rsp_item_t       out_q;
  logic            out_valid;
  logic            accept;
  logic            emit;
  logic            hit;
  logic            is_full;

  function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] base,
                                            input logic [CW-1:0] pos);
    logic [CW:0] sum;
    sum = {{(CW + 1 - SW){1'b0}}, base} + {1'b0, pos};
    if (sum >= (CW + 1)'(MAX_VERSIONS)) begin
      sum = sum - (CW + 1)'(MAX_VERSIONS);
    end
    return sum[SW-1:0];
  endfunction

  assign accept    = req.valid && req.ready;
  assign emit      = (state == S_EMIT) && (!out_valid || rsp.ready);
  assign is_full   = count >= CW'(MAX_VERSIONS);
  assign hit       = (req_q == REQ_FIND) ? (rdata.stamp <= stamp_q)
                                         : (rdata.stamp < stamp_q);
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_q;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          case (req.data.req_type)
            REQ_APPEND: state_next = is_full ? S_EMIT : S_APPEND;
            REQ_FIND:   state_next = S_SCAN;
            REQ_SWEEP:  state_next = S_SCAN;
            default:    state_next = S_EMIT;
          endcase
        end
      end
      S_APPEND: state_next = S_EMIT;
      S_SCAN: begin
        if (!chk_valid || hit) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    oldest_next    = oldest;
    count_next     = count;
    nxt_pos_next   = nxt_pos;
    chk_pos_next   = chk_pos;
    chk_valid_next = chk_valid;
    res_next       = res;
    we             = 1'b0;
    waddr          = slot_of(oldest, count);
    wdata          = '{stamp: stamp_q, handle: handle_q, len: len_q};
    raddr          = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          res_next        = '0;
          res_next.status = STS_OK;
          chk_valid_next  = (count != '0);
          chk_pos_next    = count - CW'(1);
          nxt_pos_next    = (count != '0) ? count - CW'(1) : '0;
          if (count != '0) begin
            raddr = slot_of(oldest, count - CW'(1));
          end
          if (req.data.req_type == REQ_APPEND && is_full) begin
            res_next.status = STS_FULL;
          end
        end
      end
      S_APPEND: begin
        if (chk_valid && (stamp_q < rdata.stamp)) begin
          res_next.status = STS_ORDER;
        end else begin
          we         = 1'b1;
          count_next = count + CW'(1);
        end
      end
      S_SCAN: begin
        if (nxt_pos != '0) begin
          raddr          = slot_of(oldest, nxt_pos - CW'(1));
          chk_pos_next   = nxt_pos - CW'(1);
          nxt_pos_next   = nxt_pos - CW'(1);
          chk_valid_next = 1'b1;
        end else begin
          chk_valid_next = 1'b0;
        end
        if (chk_valid && hit) begin
          if (req_q == REQ_FIND) begin
            res_next.status       = STS_OK;
            res_next.found_stamp  = rdata.stamp;
            res_next.found_handle = rdata.handle;
            res_next.found_len    = rdata.len;
          end else begin
            oldest_next = slot_of(oldest, chk_pos);
            count_next  = count - chk_pos;
          end
        end else if (!chk_valid && req_q == REQ_FIND) begin
          res_next.status = STS_NOT_FOUND;
        end
      end
      S_EMIT: begin
        res_next = res;
      end
      default: begin
        res_next = res;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      oldest    <= '0;
      count     <= '0;
      nxt_pos   <= '0;
      chk_pos   <= '0;
      chk_valid <= 1'b0;
    end else begin
      state     <= state_next;
      oldest    <= oldest_next;
      count     <= count_next;
      nxt_pos   <= nxt_pos_next;
      chk_pos   <= chk_pos_next;
      chk_valid <= chk_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (accept) begin
      req_q    <= req.data.req_type;
      stamp_q  <= req.data.stamp;
      handle_q <= req.data.payload_handle;
      len_q    <= req.data.payload_len;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    emit_item            = res;
    emit_item.held_count = 5'(count);
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_q <= emit_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_VERSIONS))
    else $error("version count above capacity");

  a_oldest_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, oldest} < (SW + 1)'(MAX_VERSIONS))
    else $error("oldest slot out of range");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    chk_valid && (state == S_SCAN || state == S_APPEND) |-> chk_pos < count)
    else $error("scan position beyond held versions");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    we |-> count < CW'(MAX_VERSIONS))
    else $error("append written into a full ring");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EMIT))
    else $error("result raised outside the emit step");

endmodule

`default_nettype wire
